[design/eehm_pkg.sv]
package eehm_pkg;

    // Point store depth and derived widths
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // Arithmetic widths of the orientation test
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int AREA_W  = PROD_W + 1;
    localparam int PT_W    = 2 * COORD_W;

    // Tag that travels with each scanned point through the orientation unit
    typedef struct packed {
        logic vld;
        logic skip;   // point is one of the pair itself
        logic last;   // final point of the scan for this pair
    } eehm_tag_t;

    // Orientation result: tag plus strictly-left verdict
    typedef struct packed {
        eehm_tag_t tag;
        logic      left;
    } eehm_ori_t;

endpackage

[design/eehm_pt_if.sv]
interface eehm_pt_if
    import eehm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last_point;

    modport source (output valid, output coord_x, output coord_y, output last_point,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input last_point,
                    output ready);
endinterface

[design/eehm_res_if.sv]
interface eehm_res_if
    import eehm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] point_index;
    logic             is_extreme;
    logic             overflow;
    logic             last_result;

    modport source (output valid, output point_index, output is_extreme, output overflow,
                    output last_result, input ready);
    modport sink   (input valid, input point_index, input is_extreme, input overflow,
                    input last_result, output ready);
endinterface

[design/eehm_ram.sv]
module eehm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/eehm_orient.sv]
module eehm_orient
    import eehm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  eehm_tag_t                 tag,
    input  logic signed [COORD_W-1:0] kx,
    input  logic signed [COORD_W-1:0] ky,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    input  logic signed [DIFF_W-1:0]  ux,
    input  logic signed [DIFF_W-1:0]  uy,
    output eehm_ori_t                 res
);
    eehm_tag_t                s1_tag_reg;
    eehm_tag_t                s2_tag_reg;
    eehm_ori_t                res_reg;
    logic signed [DIFF_W-1:0] vx_reg;
    logic signed [DIFF_W-1:0] vy_reg;
    logic signed [PROD_W-1:0] m1_reg;
    logic signed [PROD_W-1:0] m2_reg;

    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic signed [PROD_W-1:0] m1;
    logic signed [PROD_W-1:0] m2;
    logic signed [AREA_W-1:0] area;

    // Stage 1: vector from p to k
    assign vx = $signed({kx[COORD_W-1], kx}) - $signed({px[COORD_W-1], px});
    assign vy = $signed({ky[COORD_W-1], ky}) - $signed({py[COORD_W-1], py});

    // Stage 2: cross product terms
    assign m1 = ux * vy_reg;
    assign m2 = uy * vx_reg;

    // Stage 3: doubled area, left only when strictly positive
    assign area = $signed({m1_reg[PROD_W-1], m1_reg}) - $signed({m2_reg[PROD_W-1], m2_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            s1_tag_reg   <= tag;
            s2_tag_reg   <= s1_tag_reg;
            res_reg.tag  <= s2_tag_reg;
            res_reg.left <= !area[AREA_W-1] && (area != '0);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        vx_reg <= vx;
        vy_reg <= vy;
        m1_reg <= m1;
        m2_reg <= m2;
    end

    assign res = res_reg;
endmodule

[design/extreme_edge_hull_marker_core.sv]
// Channel   Port     Dir  Payload
// -------   ----     ---  -------------------------------------------------
// point     points   in   coord_x, coord_y, last_point
// result    results  out  point_index, is_extreme, overflow, last_result
//
// Points load while the core is in ST_LOAD. After the last point, the n(n-1)/2
// pairs (p, q) run in turn: read p and q, form the edge vector, scan all n points
// through the one orientation unit fed by the single RAM read port (one test per
// cycle) and await the last verdict. Results leave one per cycle unless stalled.
// points.ready is low from the last point until the final result is registered.
// Reset clears the point count, overflow and flags; the point RAM is not cleared.
module extreme_edge_hull_marker_core
    import eehm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    eehm_pt_if.sink           points,
    eehm_res_if.source        results
);
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRD,
        ST_QRD,
        ST_UVEC,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t                    state_reg,     state_next;
    logic [CNT_W-1:0]          cnt_reg,       cnt_next;
    logic                      ovf_reg,       ovf_next;
    logic [MAX_POINTS-1:0]     flags_reg,     flags_next;
    logic [IDX_W-1:0]          p_reg,         p_next;
    logic [IDX_W-1:0]          q_reg,         q_next;
    logic [IDX_W-1:0]          k_reg,         k_next;
    logic [IDX_W-1:0]          e_reg,         e_next;
    logic signed [COORD_W-1:0] px_reg,        px_next;
    logic signed [COORD_W-1:0] py_reg,        py_next;
    logic signed [DIFF_W-1:0]  ux_reg,        ux_next;
    logic signed [DIFF_W-1:0]  uy_reg,        uy_next;
    logic                      any_left_reg,  any_left_next;
    logic                      any_right_reg, any_right_next;
    eehm_tag_t                 rd_tag_reg,    rd_tag_next;
    logic                      out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]          out_idx_reg,   out_idx_next;
    logic                      out_ext_reg,   out_ext_next;
    logic                      out_ovf_reg,   out_ovf_next;
    logic                      out_last_reg,  out_last_next;

    logic                      acc;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [PT_W-1:0]           ram_rdata;
    logic signed [COORD_W-1:0] rd_x;
    logic signed [COORD_W-1:0] rd_y;
    logic [CNT_W-1:0]          n_new;
    logic [CNT_W-1:0]          n_last;
    logic                      left_hit;
    logic                      right_hit;
    logic                      now_left;
    logic                      now_right;
    eehm_ori_t                 ori;

    assign acc           = points.valid && points.ready;
    assign points.ready  = (state_reg == ST_LOAD);
    assign rd_x          = $signed(ram_rdata[PT_W-1:COORD_W]);
    assign rd_y          = $signed(ram_rdata[COORD_W-1:0]);
    assign n_last        = cnt_reg - CNT_W'(1);
    assign n_new         = (cnt_reg < MAX_CNT) ? cnt_reg + CNT_W'(1) : cnt_reg;

    // Point store: x in the upper half, y in the lower
    eehm_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata ({points.coord_x, points.coord_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared orientation unit
    eehm_orient u_orient (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (rd_tag_reg),
        .kx    (rd_x),
        .ky    (rd_y),
        .px    (px_reg),
        .py    (py_reg),
        .ux    (ux_reg),
        .uy    (uy_reg),
        .res   (ori)
    );

    // Side flags for the current pair, including the point now leaving the unit
    assign left_hit  = ori.tag.vld && !ori.tag.skip && ori.left;
    assign right_hit = ori.tag.vld && !ori.tag.skip && !ori.left;
    assign now_left  = any_left_reg || left_hit;
    assign now_right = any_right_reg || right_hit;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        flags_next     = flags_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        e_next         = e_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        any_left_next  = now_left;
        any_right_next = now_right;
        rd_tag_next    = '0;
        out_valid_next = out_valid_reg && !results.ready;
        out_idx_next   = out_idx_reg;
        out_ext_next   = out_ext_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_raddr      = k_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (acc)
                begin
                    if (cnt_reg < MAX_CNT)
                    begin
                        ram_we   = 1'b1;
                        cnt_next = n_new;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (points.last_point)
                    begin
                        p_next = '0;
                        q_next = IDX_W'(1);
                        e_next = '0;
                        if (n_new >= CNT_W'(2))
                        begin
                            state_next = ST_PRD;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_PRD:
            begin
                ram_raddr  = p_reg;
                state_next = ST_QRD;
            end
            ST_QRD:
            begin
                ram_raddr  = q_reg;
                px_next    = rd_x;
                py_next    = rd_y;
                state_next = ST_UVEC;
            end
            ST_UVEC:
            begin
                ux_next        = $signed({rd_x[COORD_W-1], rd_x})
                               - $signed({px_reg[COORD_W-1], px_reg});
                uy_next        = $signed({rd_y[COORD_W-1], rd_y})
                               - $signed({py_reg[COORD_W-1], py_reg});
                k_next         = '0;
                any_left_next  = 1'b0;
                any_right_next = 1'b0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                ram_raddr        = k_reg;
                rd_tag_next.vld  = 1'b1;
                rd_tag_next.skip = (k_reg == p_reg) || (k_reg == q_reg);
                rd_tag_next.last = ({1'b0, k_reg} == n_last);
                if ({1'b0, k_reg} == n_last)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (ori.tag.vld && ori.tag.last)
                begin
                    // Extreme edge: all other points on one side
                    if (!now_left || !now_right)
                    begin
                        flags_next[p_reg] = 1'b1;
                        flags_next[q_reg] = 1'b1;
                    end
                    // Next pair in p < q order
                    if ({1'b0, q_reg} + CNT_W'(1) < cnt_reg)
                    begin
                        q_next     = q_reg + IDX_W'(1);
                        state_next = ST_PRD;
                    end
                    else if ({1'b0, p_reg} + CNT_W'(2) < cnt_reg)
                    begin
                        p_next     = p_reg + IDX_W'(1);
                        q_next     = p_reg + IDX_W'(2);
                        state_next = ST_PRD;
                    end
                    else
                    begin
                        e_next     = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = e_reg;
                    out_ext_next   = flags_reg[e_reg];
                    out_ovf_next   = ovf_reg;
                    out_last_next  = ({1'b0, e_reg} == n_last);
                    if ({1'b0, e_reg} == n_last)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        flags_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        e_next = e_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            flags_reg     <= '0;
            rd_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
            any_left_reg  <= 1'b0;
            any_right_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            flags_reg     <= flags_next;
            rd_tag_reg    <= rd_tag_next;
            out_valid_reg <= out_valid_next;
            any_left_reg  <= any_left_next;
            any_right_reg <= any_right_next;
        end
    end

    // Pair, scan and result payload registers
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        q_reg        <= q_next;
        k_reg        <= k_next;
        e_reg        <= e_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        ux_reg       <= ux_next;
        uy_reg       <= uy_next;
        out_idx_reg  <= out_idx_next;
        out_ext_reg  <= out_ext_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.point_index = out_idx_reg;
    assign results.is_extreme  = out_ext_reg;
    assign results.overflow    = out_ovf_reg;
    assign results.last_result = out_last_reg;

    // End of a pair scan only arrives while the sequencer waits for it
    a_last_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ori.tag.vld && ori.tag.last |-> state_reg == ST_WAIT)
        else $error("pair scan ended outside wait state");

    // Pair indices stay ordered and inside the loaded set
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (p_reg < q_reg) && ({1'b0, q_reg} < cnt_reg))
        else $error("pair indices out of order or range");

    // A final point starts either the pair sweep or direct emission
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        acc && points.last_point |=> state_reg == ST_PRD || state_reg == ST_EMIT)
        else $error("final point did not start computation");

    // Emission never runs on an empty set
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cnt_reg != '0)
        else $error("emitting with no stored points");
endmodule

[bench/extreme_edge_hull_marker_core_test.sv]
`timescale 1ns / 1ps

module extreme_edge_hull_marker_core_test;
    import eehm_pkg::*;

    // One expected hull result
    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             ext;
        logic             ovf;
        logic             lst;
    } hull_result_t;

    // Coordinate flavors for random sets
    typedef enum int {
        SPREAD_FULL,    // whole 16-bit range
        SPREAD_GRID,    // tiny grid: collinear and duplicate points
        SPREAD_CORNER   // range extremes mixed with random values
    } spread_t;

    // Hull predictor and result store
    class hull_scoreboard;
        logic signed [COORD_W-1:0] xs[MAX_POINTS];
        logic signed [COORD_W-1:0] ys[MAX_POINTS];
        int unsigned  count;
        bit           ovf_seen;
        hull_result_t pending_q[$];
        int           errors;
        int           checked;
        int           sets_done;

        function longint doubled_area(int a, int b, int c);
            longint ux;
            longint uy;
            longint vx;
            longint vy;
            ux = longint'(xs[b]) - longint'(xs[a]);
            uy = longint'(ys[b]) - longint'(ys[a]);
            vx = longint'(xs[c]) - longint'(xs[a]);
            vy = longint'(ys[c]) - longint'(ys[a]);
            return ux * vy - uy * vx;
        endfunction

        // Extreme-edge marking of the stored set, then queue one result per point
        function void close_set();
            bit           flags[MAX_POINTS];
            bit           none_l;
            bit           none_r;
            hull_result_t r;
            int           n;
            n = count;
            for (int i = 0; i < MAX_POINTS; i++)
                flags[i] = 1'b0;
            for (int p = 0; p < n; p++)
            begin
                for (int q = p + 1; q < n; q++)
                begin
                    none_l = 1'b1;
                    none_r = 1'b1;
                    for (int k = 0; k < n; k++)
                    begin
                        if (k == p || k == q)
                            continue;
                        // collinear counts as right
                        if (doubled_area(p, q, k) > 0)
                            none_l = 1'b0;
                        else
                            none_r = 1'b0;
                    end
                    if (none_l || none_r)
                    begin
                        flags[p] = 1'b1;
                        flags[q] = 1'b1;
                    end
                end
            end
            for (int i = 0; i < n; i++)
            begin
                r.idx = i[IDX_W-1:0];
                r.ext = flags[i];
                r.ovf = ovf_seen;
                r.lst = (i + 1 == n);
                pending_q.push_back(r);
            end
            count    = 0;
            ovf_seen = 1'b0;
        endfunction

        // Accepted point request
        function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic lst);
            if (count < MAX_POINTS)
            begin
                xs[count] = x;
                ys[count] = y;
                count++;
            end
            else
                ovf_seen = 1'b1;
            if (lst)
                close_set();
        endfunction

        // Accepted result against the oldest expectation
        function void check_result(logic [IDX_W-1:0] idx, logic ext, logic ovf, logic lst);
            hull_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected result: idx %0d ext %0b ovf %0b last %0b",
                         $time, idx, ext, ovf, lst);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (idx !== e.idx)
            begin
                $display("%0t point_index: expected %0d actual %0d", $time, e.idx, idx);
                errors++;
            end
            if (ext !== e.ext)
            begin
                $display("%0t is_extreme (point %0d): expected %0b actual %0b",
                         $time, e.idx, e.ext, ext);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $display("%0t overflow (point %0d): expected %0b actual %0b",
                         $time, e.idx, e.ovf, ovf);
                errors++;
            end
            if (lst !== e.lst)
            begin
                $display("%0t last_result (point %0d): expected %0b actual %0b",
                         $time, e.idx, e.lst, lst);
                errors++;
            end
            if (e.lst)
                sets_done++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    eehm_pt_if  pt_bus();
    eehm_res_if res_bus();

    extreme_edge_hull_marker_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (pt_bus),
        .results (res_bus)
    );

    always #1 clk = ~clk;

    hull_scoreboard hull;
    bit             calm_tail;
    int             points_sent;
    int             sets_sent;
    int             ovf_sets;
    int             biggest_set;

    // Drive one point request, wait for it to be taken, then sometimes pause
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic lst);
        int gap;
        pt_bus.valid      <= 1'b1;
        pt_bus.coord_x    <= x;
        pt_bus.coord_y    <= y;
        pt_bus.last_point <= lst;
        @(posedge clk);
        while (!pt_bus.ready)
            @(posedge clk);
        hull.note_point(x, y, lst);
        points_sent++;
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            pt_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(spread_t spread);
        int v;
        case (spread)
            SPREAD_GRID:
                v = int'($urandom_range(0, 8)) - 4;
            SPREAD_CORNER:
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    default: v = int'($urandom);
                endcase
            default:
                v = int'($urandom);
        endcase
        return v[COORD_W-1:0];
    endfunction

    task automatic send_set(input int n, input spread_t spread);
        for (int i = 0; i < n; i++)
            send_point(pick_coord(spread), pick_coord(spread), i == n - 1);
        sets_sent++;
        if (n > MAX_POINTS)
            ovf_sets++;
        if (n > biggest_set)
            biggest_set = n;
    endtask

    task automatic wait_drained();
        while (hull.pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check accepted results, random stalls, one long hold
    initial
    begin
        int  hold_cnt;
        bit  long_hold_done;
        hold_cnt       = 0;
        long_hold_done = 1'b0;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_bus.valid && res_bus.ready)
                hull.check_result(res_bus.point_index, res_bus.is_extreme, res_bus.overflow,
                                  res_bus.last_result);
            if (hold_cnt > 0)
                hold_cnt--;
            else if (!long_hold_done && res_bus.valid && hull.sets_done == 8)
            begin
                // long backpressure while the sender keeps offering
                hold_cnt       = 400;
                long_hold_done = 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
                hold_cnt = $urandom_range(1, 14);
            res_bus.ready <= (hold_cnt == 0);
        end
    end

    // Run time guard
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        int      n;
        int      set_no;
        spread_t spread;
        hull = new();
        pt_bus.valid      <= 1'b0;
        pt_bus.coord_x    <= '0;
        pt_bus.coord_y    <= '0;
        pt_bus.last_point <= 1'b0;
        rst_n             <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point: no pair, not extreme
        send_point(COORD_W'(32767), COORD_W'(-32768), 1'b1);
        sets_sent++;
        // two points: both extreme
        send_point(COORD_W'(-32768), COORD_W'(-32768), 1'b0);
        send_point(COORD_W'(32767), COORD_W'(32767), 1'b1);
        sets_sent++;
        // collinear triple
        send_point(COORD_W'(0), COORD_W'(0), 1'b0);
        send_point(COORD_W'(1), COORD_W'(1), 1'b0);
        send_point(COORD_W'(2), COORD_W'(2), 1'b1);
        sets_sent++;
        // full-range square, center and a point on an edge
        send_point(COORD_W'(-32768), COORD_W'(-32768), 1'b0);
        send_point(COORD_W'(32767), COORD_W'(-32768), 1'b0);
        send_point(COORD_W'(32767), COORD_W'(32767), 1'b0);
        send_point(COORD_W'(-32768), COORD_W'(32767), 1'b0);
        send_point(COORD_W'(0), COORD_W'(0), 1'b0);
        send_point(COORD_W'(0), COORD_W'(-32768), 1'b1);
        sets_sent++;
        // duplicates
        send_point(COORD_W'(5), COORD_W'(5), 1'b0);
        send_point(COORD_W'(5), COORD_W'(5), 1'b0);
        send_point(COORD_W'(5), COORD_W'(5), 1'b1);
        sets_sent++;
        biggest_set = 6;

        // sender waits for every result of the directed sets
        pt_bus.valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // random sets; one full store and one overflowing store
        set_no = 0;
        while (points_sent < 318)
        begin
            if (points_sent >= 285)
                calm_tail = 1'b1;
            if (set_no == 5)
                n = MAX_POINTS;
            else if (set_no == 11)
                n = MAX_POINTS + $urandom_range(1, 4);
            else if ($urandom_range(0, 4) == 0)
                n = $urandom_range(9, 16);
            else
                n = $urandom_range(1, 8);
            spread = spread_t'($urandom_range(0, 2));
            send_set(n, spread);
            set_no++;
        end
        pt_bus.valid <= 1'b0;

        // drain, then watch for stray results
        wait_drained();
        repeat (100) @(posedge clk);

        $display("Sent %0d points in %0d sets (largest %0d, %0d over store depth).",
                 points_sent, sets_sent, biggest_set, ovf_sets);
        $display("Checked %0d hull results across %0d completed sets.",
                 hull.checked, hull.sets_done);
        if (hull.errors == 0 && hull.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
design/eehm_pkg.sv
design/eehm_pt_if.sv
design/eehm_res_if.sv
design/eehm_ram.sv
design/eehm_orient.sv
design/extreme_edge_hull_marker_core.sv
bench/extreme_edge_hull_marker_core_test.sv
